FILE: design/escdec_pkg.sv
// escdec_pkg: shared types and constants of the escape sequence decoder
// item structs, decode mode enum, command queue types and character codes
// no dependencies
package escdec_pkg;

  // input and result items
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // decode mode of the front
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_OCT   = 3'd2,
    MODE_DEC   = 3'd3,
    MODE_HEX   = 3'd4
  } mode_e;

  // one queued command: the 1 to 3 result bytes of one input item
  localparam int unsigned CMD_BYTES = 3;

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [1:0]                cnt;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmdq_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_rd_t;

  // command queue geometry, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // reset value of the escape byte, backslash
  localparam logic [7:0] ESC_RESET = 8'h5c;

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UE  = 8'h45;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LB  = 8'h62;
  localparam logic [7:0] CH_LE  = 8'h65;
  localparam logic [7:0] CH_LF  = 8'h66;
  localparam logic [7:0] CH_LN  = 8'h6e;
  localparam logic [7:0] CH_LR  = 8'h72;
  localparam logic [7:0] CH_LT  = 8'h74;
  localparam logic [7:0] CH_LV  = 8'h76;
  localparam logic [7:0] CH_LX  = 8'h78;

  // control codes
  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_HT  = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0a;
  localparam logic [7:0] CC_VT  = 8'h0b;
  localparam logic [7:0] CC_FF  = 8'h0c;
  localparam logic [7:0] CC_CR  = 8'h0d;
  localparam logic [7:0] CC_ESC = 8'h1b;

endpackage

FILE: design/escdec_front.sv
// escdec_front: decode state machine, one input item per cycle while accept_i is high
// turns each item into a command of 0 to 3 result bytes
// depends on escdec_pkg
module escdec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           escape_byte_i,
  input  logic                 accept_i,
  input  escdec_pkg::in_item_t in_item_i,
  output escdec_pkg::cmdq_wr_t wr_o
);
  import escdec_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;

  logic [7:0] b;
  logic       last;
  logic       is_esc;
  logic       plain_emit;

  logic       dig_valid;
  logic [3:0] dig_val;
  logic [7:0] acc_mul;
  logic [7:0] acc_dig;
  logic [1:0] cnt_dig;
  logic       dig_done;

  logic [7:0] r0, r1, r2;
  logic [1:0] n;

  assign b          = in_item_i.in_byte;
  assign last       = in_item_i.in_last;
  assign is_esc     = (b == escape_byte_i);
  assign plain_emit = !is_esc || last;

  // digit recognition for the current number base
  always_comb begin
    dig_valid = 1'b0;
    dig_val   = 4'd0;
    acc_mul   = acc_q;
    case (mode_q)
      MODE_OCT: begin
        acc_mul = {acc_q[4:0], 3'b000};
        if (b inside {[CH_0:CH_7]}) begin
          dig_valid = 1'b1;
          dig_val   = b[3:0];
        end
      end
      MODE_DEC: begin
        acc_mul = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0};
        if (b inside {[CH_0:CH_9]}) begin
          dig_valid = 1'b1;
          dig_val   = b[3:0];
        end
      end
      MODE_HEX: begin
        acc_mul = {acc_q[3:0], 4'b0000};
        if (b inside {[CH_0:CH_9]}) begin
          dig_valid = 1'b1;
          dig_val   = b[3:0];
        end else if (b inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
          dig_valid = 1'b1;
          dig_val   = b[3:0] + 4'd9;
        end
      end
      default: begin
        acc_mul = acc_q;
      end
    endcase
  end

  assign acc_dig  = acc_mul + {4'b0000, dig_val};
  assign cnt_dig  = cnt_q + 2'd1;
  assign dig_done = last || ((mode_q == MODE_HEX) ? (cnt_dig >= 2'd2) : (cnt_dig == 2'd3));

  // next state
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (accept_i) begin
      case (mode_q)
        MODE_ESC: begin
          mode_d = MODE_PLAIN;
          if (b == CH_0) begin
            acc_d = 8'd0;
            cnt_d = 2'd0;
            if (!last) mode_d = MODE_OCT;
          end else if (b == CH_LX) begin
            acc_d = 8'd0;
            cnt_d = 2'd0;
            if (!last) mode_d = MODE_HEX;
          end else if (b inside {[CH_1:CH_9]}) begin
            acc_d = b - CH_0;
            cnt_d = 2'd1;
            if (!last) mode_d = MODE_DEC;
          end
        end
        MODE_OCT, MODE_DEC, MODE_HEX: begin
          if (dig_valid) begin
            acc_d = acc_dig;
            cnt_d = cnt_dig;
            if (dig_done) mode_d = MODE_PLAIN;
          end else begin
            mode_d = plain_emit ? MODE_PLAIN : MODE_ESC;
          end
        end
        default: begin
          mode_d = plain_emit ? MODE_PLAIN : MODE_ESC;
        end
      endcase
      // end of string returns everything to reset values
      if (last) begin
        mode_d = MODE_PLAIN;
        acc_d  = 8'd0;
        cnt_d  = 2'd0;
      end
    end
  end

  // result bytes of the current item
  always_comb begin
    r0 = b;
    r1 = b;
    r2 = b;
    n  = 2'd0;
    case (mode_q)
      MODE_ESC: begin
        n = 2'd1;
        case (b)
          CH_NUL:       r0 = escape_byte_i;
          CH_LA:        r0 = CC_BEL;
          CH_LB:        r0 = CC_BS;
          CH_LE, CH_UE: r0 = CC_ESC;
          CH_LF:        r0 = CC_FF;
          CH_LN:        r0 = CC_LF;
          CH_LR:        r0 = CC_CR;
          CH_LT:        r0 = CC_HT;
          CH_LV:        r0 = CC_VT;
          CH_0: begin
            r0 = 8'd0;
            n  = last ? 2'd1 : 2'd0;
          end
          CH_LX: begin
            r0 = escape_byte_i;
            r1 = CH_LX;
            n  = last ? 2'd2 : 2'd0;
          end
          default: begin
            if (b inside {[CH_1:CH_9]}) begin
              r0 = b - CH_0;
              n  = last ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
      MODE_OCT, MODE_DEC, MODE_HEX: begin
        if (dig_valid) begin
          r0 = acc_dig;
          n  = dig_done ? 2'd1 : 2'd0;
        end else if (mode_q == MODE_HEX && cnt_q == 2'd0) begin
          // hex prefix with no digit
          r0 = escape_byte_i;
          r1 = CH_LX;
          n  = plain_emit ? 2'd3 : 2'd2;
        end else begin
          r0 = acc_q;
          n  = plain_emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        n = plain_emit ? 2'd1 : 2'd0;
      end
    endcase
  end

  assign wr_o.push      = accept_i && (n != 2'd0);
  assign wr_o.cmd.bytes = {r2, r1, r0};
  assign wr_o.cmd.cnt   = n;
  assign wr_o.cmd.last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      acc_q  <= 8'd0;
      cnt_q  <= 2'd0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: design/escdec_queue.sv
// escdec_queue: short command queue between front and back
// register array with read and write pointers
// depends on escdec_pkg
module escdec_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  escdec_pkg::cmdq_wr_t wr_i,
  output logic                 full_o,
  output escdec_pkg::cmdq_rd_t rd_o,
  input  logic                 deq_i
);
  import escdec_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_o.valid = (count_q != '0);
  assign rd_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = wr_i.push && !full_o;
  assign do_pop  = deq_i && rd_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/escdec_back.sv
// escdec_back: unpacks queued commands into result items, one per cycle while the output register is empty or popped
// holds the output register of the result channel
// depends on escdec_pkg
module escdec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  escdec_pkg::cmdq_rd_t  rd_i,
  output logic                  deq_o,
  input  logic                  pop,
  output logic                  empty,
  output escdec_pkg::out_item_t out_item_o
);
  import escdec_pkg::*;

  logic       vld_q, vld_d;
  logic [1:0] sel_q, sel_d;
  out_item_t  out_q, out_d;
  logic       load;
  logic       fin;
  logic [7:0] sel_byte;

  assign load = rd_i.valid && (!vld_q || pop);
  assign fin  = (sel_q == rd_i.cmd.cnt - 2'd1);

  always_comb begin
    case (sel_q)
      2'd0:    sel_byte = rd_i.cmd.bytes[0];
      2'd1:    sel_byte = rd_i.cmd.bytes[1];
      default: sel_byte = rd_i.cmd.bytes[2];
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    sel_d = sel_q;
    out_d = out_q;
    if (load) begin
      vld_d               = 1'b1;
      out_d.out_byte      = sel_byte;
      out_d.run_last      = fin;
      out_d.string_end    = fin && rd_i.cmd.last;
      sel_d               = fin ? 2'd0 : sel_q + 2'd1;
    end else if (pop) begin
      vld_d = 1'b0;
    end
  end

  assign deq_o      = load && fin;
  assign empty      = !vld_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      sel_q <= sel_d;
    end
  end

endmodule

FILE: design/escape_sequence_decoder.sv
// escape_sequence_decoder: top level of the backslash escape decoder
// instantiates escdec_front, escdec_queue and escdec_back
// depends on escdec_pkg
//
// usage
// - input channel: in_item_i carries one byte of the escaped string and a
//   mark on its last byte; the item is taken at a clock edge with push high
//   and full low
// - result channel: while empty is low, out_item_o holds the oldest decoded
//   byte; it is taken at a clock edge with pop high and empty low
// - run_last marks the final result of one input item, string_end the final
//   decoded byte of a string; one input item gives 0 to 3 results
// - cfg_we_i with cfg_wdata_i writes the escape byte (backslash after reset);
//   write it only while the block is idle
// - the results of a taken item pass through the command queue and then the
//   output register before they reach the ports
// - throughput: one input item per cycle while full is low and one result per
//   cycle while the receiver pops; the back end sends results of a multi-byte
//   command in consecutive cycles, so items that give 2 or 3 results fill the
//   4-entry command queue and full rises until the back end catches up
// - a stalled receiver (pop low) holds the result register; the front keeps
//   taking items until the command queue is full
// - reset clears the decode state, the queue and the output valid flag and
//   sets the escape byte to backslash; no items are held after reset
module escape_sequence_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  escdec_pkg::in_item_t  in_item_i,
  input  logic                  pop,
  output logic                  empty,
  output escdec_pkg::out_item_t out_item_o
);
  import escdec_pkg::*;

  logic [7:0] esc_q;
  logic       accept;
  cmdq_wr_t   q_wr;
  cmdq_rd_t   q_rd;
  logic       q_deq;

  // configured escape byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_RESET;
    end else if (cfg_we_i) begin
      esc_q <= cfg_wdata_i;
    end
  end

  // an item is taken whenever push is high and the command queue has room
  assign accept = push && !full;

  // front: classify bytes and build commands
  escdec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .escape_byte_i (esc_q),
    .accept_i      (accept),
    .in_item_i     (in_item_i),
    .wr_o          (q_wr)
  );

  // queue decouples the front from the back
  escdec_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (full),
    .rd_o   (q_rd),
    .deq_i  (q_deq)
  );

  // back: one result byte per cycle into the output register while it is empty or popped
  escdec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (q_rd),
    .deq_o      (q_deq),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

endmodule

FILE: tb/escape_sequence_decoder_test.sv
`timescale 1ns / 100ps
// escape_sequence_decoder_test: self-checking testbench of the escape sequence decoder
// drives escaped strings through the queue-style ports, predicts every decoded byte
// depends on escdec_pkg and escape_sequence_decoder
module escape_sequence_decoder_test;
  import escdec_pkg::*;

  // timing and run limits
  localparam int unsigned CYCLE_LIMIT  = 40000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned MAX_PRINTS   = 50;

  // extra letters, and the bytes that follow the escape byte in the random strings
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_LQ = 8'h71;
  localparam logic [7:0] CH_LZ = 8'h7a;
  localparam logic [7:0] ESCAPE_LETTERS [10] = '{
    CH_LA, CH_LB, CH_LE, CH_UE, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV, CH_LQ
  };

  // block ports, the inputs known from time zero
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       push        = 1'b0;
  logic       full;
  in_item_t   in_item     = '0;
  logic       pop         = 1'b0;
  logic       empty;
  out_item_t  out_item;

  // outputs as seen just before each rising edge
  logic       full_s  = 1'b1;
  logic       empty_s = 1'b1;
  out_item_t  out_s   = '0;

  // shared control between the stimulus and the result sink
  bit          idle_on      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;

  // decoder state as predicted here
  logic [7:0] esc_byte      = ESC_RESET;
  mode_e      mode_now      = MODE_PLAIN;
  logic [7:0] number_value  = 8'h00;
  logic [1:0] number_digits = 2'd0;

  // decoded bytes of the item being predicted, and all bytes still due
  logic [7:0] item_bytes[$];
  out_item_t  expected_bytes[$];

  escape_sequence_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sample the outputs at the falling edge before the edge that acts on them
  always @(negedge clk_i) begin
    full_s  = full;
    empty_s = empty;
    out_s   = out_item;
  end

  // run limit: a hang anywhere ends here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // prediction of the decoded bytes
  // ---------------------------------------------------------------------------

  // at most three bytes come out of one item
  function automatic void emit_byte(input logic [7:0] b);
    if (item_bytes.size() < 3) item_bytes.push_back(b);
  endfunction

  // plain text: the escape byte opens a sequence unless the string ends on it
  function automatic void plain_byte(input logic [7:0] b, input logic last);
    if (b == esc_byte) begin
      if (last) emit_byte(esc_byte);
      else mode_now = MODE_ESC;
    end else begin
      emit_byte(b);
    end
  endfunction

  // byte right after the escape byte
  function automatic void escaped_byte(input logic [7:0] c, input logic last);
    mode_now = MODE_PLAIN;
    case (c)
      CH_NUL: emit_byte(esc_byte);
      CH_LA:  emit_byte(CC_BEL);
      CH_LB:  emit_byte(CC_BS);
      CH_LE,
      CH_UE:  emit_byte(CC_ESC);
      CH_LF:  emit_byte(CC_FF);
      CH_LN:  emit_byte(CC_LF);
      CH_LR:  emit_byte(CC_CR);
      CH_LT:  emit_byte(CC_HT);
      CH_LV:  emit_byte(CC_VT);
      CH_0: begin
        // octal prefix, a bare one at the string end is zero
        number_value  = 8'h00;
        number_digits = 2'd0;
        if (last) emit_byte(8'h00);
        else mode_now = MODE_OCT;
      end
      CH_LX: begin
        // hex prefix, at the string end the escape byte and the x come out
        number_value  = 8'h00;
        number_digits = 2'd0;
        if (last) begin
          emit_byte(esc_byte);
          emit_byte(CH_LX);
        end else begin
          mode_now = MODE_HEX;
        end
      end
      default: begin
        if (c inside {[CH_1:CH_9]}) begin
          // the first decimal digit is part of the number
          number_value  = c - CH_0;
          number_digits = 2'd1;
          if (last) emit_byte(number_value);
          else mode_now = MODE_DEC;
        end else begin
          emit_byte(c);
        end
      end
    endcase
  endfunction

  // one byte inside an octal, decimal or hex number
  function automatic void number_byte(input logic [7:0] b, input logic last,
                                      input int unsigned base, input int unsigned limit);
    int digit;
    digit = -1;
    if (base == 16) begin
      if (b inside {[CH_0:CH_9]}) digit = b - CH_0;
      else if (b inside {[CH_LA:CH_LF]}) digit = b - CH_LA + 10;
      else if (b inside {[CH_UA:CH_UF]}) digit = b - CH_UA + 10;
    end else if (b inside {[CH_0:((base == 8) ? CH_7 : CH_9)]}) begin
      digit = b - CH_0;
    end

    if (digit >= 0) begin
      // value wraps modulo 256, the digit counter modulo 4
      number_value  = 8'(number_value * base + digit);
      number_digits = number_digits + 2'd1;
      if (number_digits >= limit || last) begin
        emit_byte(number_value);
        mode_now = MODE_PLAIN;
      end
      return;
    end

    // a non-digit ends the number and is then decoded as plain text
    if (base == 16 && number_digits == 2'd0) begin
      emit_byte(esc_byte);
      emit_byte(CH_LX);
    end else begin
      emit_byte(number_value);
    end
    mode_now = MODE_PLAIN;
    plain_byte(b, last);
  endfunction

  // expected results of one accepted item, appended to the store
  function automatic void decode_item(input in_item_t it);
    out_item_t res;
    item_bytes.delete();
    case (mode_now)
      MODE_ESC: escaped_byte(it.in_byte, it.in_last);
      MODE_OCT: number_byte(it.in_byte, it.in_last, 8, 3);
      MODE_DEC: number_byte(it.in_byte, it.in_last, 10, 3);
      MODE_HEX: number_byte(it.in_byte, it.in_last, 16, 2);
      default: begin
        mode_now = MODE_PLAIN;
        plain_byte(it.in_byte, it.in_last);
      end
    endcase
    foreach (item_bytes[k]) begin
      res.out_byte   = item_bytes[k];
      res.run_last   = (k == item_bytes.size() - 1);
      res.string_end = res.run_last && it.in_last;
      expected_bytes.push_back(res);
    end
    // every string starts over in plain text
    if (it.in_last) begin
      mode_now      = MODE_PLAIN;
      number_value  = 8'h00;
      number_digits = 2'd0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_error($sformatf("result byte %h with nothing expected", got.out_byte));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte != want.out_byte)
      report_error($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    if (got.run_last != want.run_last)
      report_error($sformatf("run_last %b, expected %b on byte %h",
                             got.run_last, want.run_last, want.out_byte));
    if (got.string_end != want.string_end)
      report_error($sformatf("string_end %b, expected %b on byte %h",
                             got.string_end, want.string_end, want.out_byte));
  endtask

  // result sink: random stalls, and a long hold-off when the stimulus asks
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty_s) check_result(out_s);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= !(idle_on && $urandom_range(99) < 23);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item after a random gap, hold it until taken, then predict it
  task automatic send_item(input in_item_t it);
    while (idle_on && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full_s);
    decode_item(it);
  endtask

  // stop offering, wait for every expected byte, then let the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // escape byte write, only while the decoder is drained
  task automatic write_escape(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    esc_byte = value;
  endtask

  // random strings made mostly of well-formed escape sequences, some noise
  task automatic send_random_strings(input int unsigned item_goal);
    logic [7:0]  text[$];
    int unsigned sent;
    int unsigned hex_digit;
    sent = 0;
    while (sent < item_goal) begin
      text.delete();
      if ($urandom_range(9) == 0) begin
        // raw noise, any byte may end a string
        repeat ($urandom_range(1, 6)) begin
          send_item({8'($urandom), 1'($urandom)});
          sent++;
        end
        continue;
      end
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(9))
          0, 1, 2: text.push_back(8'($urandom));
          3: begin
            text.push_back(esc_byte);
            text.push_back(ESCAPE_LETTERS[$urandom_range(9)]);
          end
          4: begin
            // octal, now and then with an 8 or 9 that ends it
            text.push_back(esc_byte);
            text.push_back(CH_0);
            repeat ($urandom_range(0, 4))
              text.push_back(8'($urandom_range(CH_0, ($urandom_range(3) == 0) ? CH_9 : CH_7)));
          end
          5: begin
            text.push_back(esc_byte);
            text.push_back(8'($urandom_range(CH_1, CH_9)));
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(CH_0, CH_9)));
          end
          6: begin
            text.push_back(esc_byte);
            text.push_back(CH_LX);
            repeat ($urandom_range(0, 3)) begin
              hex_digit = $urandom_range(15);
              if (hex_digit < 10) text.push_back(8'(CH_0 + hex_digit));
              else text.push_back(8'((($urandom_range(1)) ? CH_LA : CH_UA) + hex_digit - 10));
            end
          end
          7: begin
            text.push_back(esc_byte);
            text.push_back(8'($urandom));
          end
          8: begin
            // escape with a nul, or a lone escape before the next part
            text.push_back(esc_byte);
            if ($urandom_range(1)) text.push_back(CH_NUL);
          end
          default: text.push_back(8'($urandom_range(CH_0, CH_LZ)));
        endcase
      end
      foreach (text[k]) begin
        send_item({text[k], k == text.size() - 1});
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // byte extremes, control letters and the corner cases of each number kind
  task automatic test_directed_sequences();
    in_item_t seq [25];
    seq = '{
      {8'hff, 1'b0}, {8'h00, 1'b0},
      {ESC_RESET, 1'b0}, {CH_LA, 1'b0},
      {ESC_RESET, 1'b0}, {CH_UE, 1'b0},
      // nul after the escape gives the escape byte
      {ESC_RESET, 1'b0}, {CH_NUL, 1'b0},
      // hex prefix without digit, the g is then plain text
      {ESC_RESET, 1'b0}, {CH_LX, 1'b0}, {CH_LG, 1'b0},
      // three octal sevens wrap to ff
      {ESC_RESET, 1'b0}, {CH_0, 1'b0}, {CH_7, 1'b0}, {CH_7, 1'b0}, {CH_7, 1'b0},
      // bare octal prefix
      {ESC_RESET, 1'b0}, {CH_0, 1'b0}, {CH_LZ, 1'b0},
      // string ends inside a decimal number
      {ESC_RESET, 1'b0}, {CH_1, 1'b0}, {8'h32, 1'b1},
      // string ends on the hex prefix
      {ESC_RESET, 1'b0}, {CH_LX, 1'b1},
      // string ends on the escape byte
      {ESC_RESET, 1'b1}
    };
    foreach (seq[k]) send_item(seq[k]);
    wait_drained();
  endtask

  // receiver holds off while groups of escape, x and g keep coming, each giving three bytes
  task automatic test_full_stall();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (8) begin
      send_item({esc_byte, 1'b0});
      send_item({CH_LX, 1'b0});
      send_item({CH_LG, 1'b0});
    end
    send_item({esc_byte, 1'b1});
    idle_on = 1'b1;
    wait_drained();
  endtask

  // random strings with the reset escape byte, part of it without any idling
  task automatic test_random_strings();
    send_random_strings(30);
    idle_on = 1'b0;
    send_random_strings(25);
    idle_on = 1'b1;
    send_random_strings(15);
    send_item({8'($urandom), 1'b1});
    wait_drained();
  endtask

  // same traffic under the extreme escape bytes and a random one
  task automatic test_escape_settings();
    logic [7:0] settings [3];
    settings = '{8'h00, 8'hff, 8'($urandom)};
    foreach (settings[k]) begin
      write_escape(settings[k]);
      send_random_strings(20);
      send_item({8'($urandom), 1'b1});
      wait_drained();
    end
    write_escape(ESC_RESET);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_escape(ESC_RESET);

    test_directed_sequences();
    test_full_stall();
    test_random_strings();
    test_escape_settings();

    push <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
